[rtl/bpc_pkg.sv]
package bpc_pkg;

    localparam int unsigned TICK_W   = 8;
    localparam int unsigned WINDOW_W = 8;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd50;

    localparam logic [TICK_W-1:0] SINGLE_HOLD  = 8'd15;
    localparam logic [TICK_W-1:0] FLASH1_END   = 8'd30;
    localparam logic [TICK_W-1:0] FLASH2_BEGIN = 8'd50;
    localparam logic [TICK_W-1:0] FLASH2_END   = 8'd75;
    localparam logic [TICK_W-1:0] FLASH3_BEGIN = 8'd95;
    localparam logic [TICK_W-1:0] FLASH3_END   = 8'd120;
    localparam logic [TICK_W-1:0] TICK_MAX     = 8'd255;

    // register word index, taken from paddr[2]
    localparam logic REG_DOUBLE_WINDOW = 1'b0;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_PRESS  = 3'd1,
        PH_WAIT   = 3'd2,
        PH_HOLD   = 3'd3,
        PH_SECOND = 3'd4,
        PH_FLASH  = 3'd5
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [TICK_W-1:0]   ticks;
        logic                led;
        logic                single_ev;
        logic                double_ev;
    } t_step_res;

endpackage

[rtl/button_press_classifier.sv]
// Single/double press classifier for two buttons sharing one LED. Each input
// transaction is one UI tick; only the button picked by i_use_second advances.
// A transaction is registered, then classified by one pass through the phase
// logic into the result register once that register is empty or read out, so
// one transaction is accepted per cycle while i_ready stays high. The
// output register and the input register together let a new transaction be
// accepted while a result waits for i_ready. double_window is written over the
// APB port at address 0 and reads back in the low byte.
module button_press_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_first_pressed,
    input  logic                            i_second_pressed,
    input  logic                            i_use_second,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_led_on,
    output logic                            o_single_event,
    output logic                            o_double_event,
    output logic                            o_event_source,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpc_pkg::APB_AW-1:0]      paddr,
    input  logic [bpc_pkg::APB_DW-1:0]      pwdata,
    output logic [bpc_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);
    import bpc_pkg::*;

    logic                  r_in_valid;
    logic                  r_in_first;
    logic                  r_in_second;
    logic                  r_in_sel;

    t_phase                r_first_phase;
    logic [TICK_W-1:0]     r_first_ticks;
    t_phase                r_second_phase;
    logic [TICK_W-1:0]     r_second_ticks;
    logic                  r_led;
    logic [WINDOW_W-1:0]   r_window;

    logic                  r_out_valid;
    logic                  r_out_led;
    logic                  r_out_single;
    logic                  r_out_double;
    logic                  r_out_source;

    logic                  out_load;
    logic                  in_take;
    logic                  cfg_wr;
    t_phase                cur_phase;
    logic [TICK_W-1:0]     cur_ticks;
    logic                  cur_pressed;
    t_step_res             step_res;

    assign out_load = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready  = !r_in_valid || out_load;
    assign in_take  = i_valid && o_ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DOUBLE_WINDOW);
    assign prdata = (paddr[2] == REG_DOUBLE_WINDOW)
                  ? {{(APB_DW-WINDOW_W){1'b0}}, r_window} : '0;

    assign cur_phase   = r_in_sel ? r_second_phase : r_first_phase;
    assign cur_ticks   = r_in_sel ? r_second_ticks : r_first_ticks;
    assign cur_pressed = r_in_sel ? r_in_second : r_in_first;

    bpc_step u_step (
        .i_phase   (cur_phase),
        .i_ticks   (cur_ticks),
        .i_pressed (cur_pressed),
        .i_window  (r_window),
        .i_led     (r_led),
        .o_res     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (cfg_wr) begin
            r_window <= pwdata[WINDOW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (out_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_first  <= i_first_pressed;
            r_in_second <= i_second_pressed;
            r_in_sel    <= i_use_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_phase  <= PH_IDLE;
            r_first_ticks  <= '0;
            r_second_phase <= PH_IDLE;
            r_second_ticks <= '0;
            r_led          <= 1'b0;
        end else if (out_load) begin
            r_led <= step_res.led;
            if (r_in_sel) begin
                r_second_phase <= step_res.phase;
                r_second_ticks <= step_res.ticks;
            end else begin
                r_first_phase <= step_res.phase;
                r_first_ticks <= step_res.ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_led    <= step_res.led;
            r_out_single <= step_res.single_ev;
            r_out_double <= step_res.double_ev;
            r_out_source <= (step_res.single_ev || step_res.double_ev) && r_in_sel;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_led_on       = r_out_led;
    assign o_single_event = r_out_single;
    assign o_double_event = r_out_double;
    assign o_event_source = r_out_source;

endmodule

[rtl/bpc_step.sv]
module bpc_step (
    input  bpc_pkg::t_phase                       i_phase,
    input  logic [bpc_pkg::TICK_W-1:0]            i_ticks,
    input  logic                                  i_pressed,
    input  logic [bpc_pkg::WINDOW_W-1:0]          i_window,
    input  logic                                  i_led,
    output bpc_pkg::t_step_res                    o_res
);
    import bpc_pkg::*;

    logic [TICK_W-1:0] tick_inc;
    t_phase            next_phase;

    assign tick_inc = (i_ticks == TICK_MAX) ? TICK_MAX : i_ticks + 1'b1;

    // next phase
    always_comb begin
        next_phase = PH_IDLE;
        unique case (i_phase)
            PH_IDLE: begin
                next_phase = i_pressed ? PH_PRESS : PH_IDLE;
            end
            PH_PRESS: begin
                if (!i_pressed) begin
                    next_phase = PH_WAIT;
                end else if (tick_inc > SINGLE_HOLD) begin
                    next_phase = PH_HOLD;
                end else begin
                    next_phase = PH_PRESS;
                end
            end
            PH_WAIT: begin
                if (tick_inc >= i_window) begin
                    next_phase = PH_IDLE;
                end else if (i_pressed) begin
                    next_phase = PH_SECOND;
                end else begin
                    next_phase = PH_WAIT;
                end
            end
            PH_HOLD: begin
                next_phase = i_pressed ? PH_HOLD : PH_IDLE;
            end
            PH_SECOND: begin
                next_phase = i_pressed ? PH_SECOND : PH_FLASH;
            end
            PH_FLASH: begin
                next_phase = (tick_inc > FLASH3_END) ? PH_IDLE : PH_FLASH;
            end
            default: begin
                next_phase = PH_IDLE;
            end
        endcase
    end

    // timer, LED and events
    always_comb begin
        o_res           = '0;
        o_res.phase     = next_phase;
        o_res.ticks     = i_ticks;
        o_res.led       = i_led;
        o_res.single_ev = 1'b0;
        o_res.double_ev = 1'b0;
        unique case (i_phase)
            PH_IDLE: begin
            end
            PH_PRESS: begin
                if (tick_inc > SINGLE_HOLD) begin
                    o_res.ticks     = '0;
                    o_res.single_ev = 1'b1;
                end else begin
                    o_res.ticks = tick_inc;
                end
            end
            PH_WAIT: begin
                o_res.ticks = (tick_inc >= i_window) ? '0 : tick_inc;
            end
            PH_HOLD: begin
                o_res.led = i_pressed;
                if (!i_pressed) begin
                    o_res.ticks = '0;
                end
            end
            PH_SECOND: begin
                o_res.double_ev = !i_pressed;
            end
            PH_FLASH: begin
                o_res.ticks = tick_inc;
                if (tick_inc > FLASH3_END) begin
                    o_res.ticks = '0;
                    o_res.led   = 1'b0;
                end else begin
                    o_res.led = (tick_inc <= FLASH1_END)
                             || (tick_inc >= FLASH2_BEGIN && tick_inc <= FLASH2_END)
                             || (tick_inc >= FLASH3_BEGIN);
                end
            end
            default: begin
                o_res.ticks = '0;
            end
        endcase
    end

endmodule

[rtl/bpc_checker.sv]
module bpc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_valid,
    input  logic                            i_ready,
    input  logic                            o_led_on,
    input  logic                            o_single_event,
    input  logic                            o_double_event,
    input  logic                            o_event_source
);

    // a tick raises at most one kind of event
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_single_event && o_double_event))
        else $error("single and double event in one transaction");

    // source is only flagged alongside an event
    a_source_needs_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_source) |-> (o_single_event || o_double_event))
        else $error("event source set without an event");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_led_on)
            && $stable(o_single_event) && $stable(o_double_event)
            && $stable(o_event_source)))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_led_on       (o_led_on),
    .o_single_event (o_single_event),
    .o_double_event (o_double_event),
    .o_event_source (o_event_source)
);

[tb/sv/button_press_classifier_tb.sv]
module button_press_classifier_tb;
    import bpc_pkg::*;

    typedef struct packed {
        logic led_on;
        logic single_event;
        logic double_event;
        logic event_source;
    } t_tick_res;

    localparam logic [APB_AW-1:0] ADDR_DOUBLE_WINDOW = {REG_DOUBLE_WINDOW, 2'b00};
    localparam int N_RANDOM = 1800;
    localparam int N_PHASES = 7;
    localparam int N_DIR    = 24;

    // first, second, use_second, typed, led, single, double, source
    localparam logic [7:0] DIR_ROWS [N_DIR] = '{
        8'b000_1_0000,
        8'b100_0_0000,
        8'b110_0_0000, 8'b100_0_0000, 8'b110_0_0000, 8'b100_0_0000, 8'b110_0_0000,
        8'b100_0_0000, 8'b110_0_0000, 8'b100_0_0000, 8'b110_0_0000, 8'b100_0_0000,
        8'b110_0_0000, 8'b100_0_0000, 8'b110_0_0000, 8'b100_0_0000, 8'b110_0_0000,
        8'b000_1_0100,  // released on the decision tick
        8'b100_0_0000,
        8'b000_1_0010,
        8'b111_0_0000,
        8'b101_0_0000,
        8'b011_0_0000,
        8'b001_1_0011
    };

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_valid          = 1'b0;
    logic                i_first_pressed  = 1'b0;
    logic                i_second_pressed = 1'b0;
    logic                i_use_second     = 1'b0;
    logic                i_ready          = 1'b0;
    logic                psel             = 1'b0;
    logic                penable          = 1'b0;
    logic                pwrite           = 1'b0;
    logic [APB_AW-1:0]   paddr            = '0;
    logic [APB_DW-1:0]   pwdata           = '0;
    logic                o_ready;
    logic                o_valid;
    logic                o_led_on;
    logic                o_single_event;
    logic                o_double_event;
    logic                o_event_source;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    button_press_classifier i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_first_pressed  (i_first_pressed),
        .i_second_pressed (i_second_pressed),
        .i_use_second     (i_use_second),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_led_on         (o_led_on),
        .o_single_event   (o_single_event),
        .o_double_event   (o_double_event),
        .o_event_source   (o_event_source),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #5 i_clk = ~i_clk;

    logic [WINDOW_W-1:0] window_cfg;
    t_phase              btn_phase [2];
    logic [TICK_W-1:0]   btn_ticks [2];
    logic                led_level;

    t_tick_res tick_results_q [$];
    int        n_items    = 0;
    int        n_single   = 0;
    int        n_double   = 0;
    int        n_mism     = 0;
    int        burst_left = 0;
    int        rdy_mode   = 0;
    int        rdy_cnt    = 0;

    function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] t);
        return (t == TICK_MAX) ? TICK_MAX : t + 1'b1;
    endfunction

    function automatic t_tick_res classify_tick(input logic fp, input logic sp,
                                                input logic us);
        t_tick_res         r;
        logic              pr;
        logic [TICK_W-1:0] t;
        r  = '0;
        pr = us ? sp : fp;
        case (btn_phase[us])
            PH_IDLE: begin
                if (pr) btn_phase[us] = PH_PRESS;
            end
            PH_PRESS: begin
                btn_ticks[us] = sat_inc(btn_ticks[us]);
                if (btn_ticks[us] > SINGLE_HOLD) begin
                    btn_phase[us]  = PH_HOLD;
                    btn_ticks[us]  = '0;
                    r.single_event = 1'b1;
                end
                if (!pr) btn_phase[us] = PH_WAIT;
            end
            PH_WAIT: begin
                btn_ticks[us] = sat_inc(btn_ticks[us]);
                if (btn_ticks[us] >= window_cfg) begin
                    btn_ticks[us] = '0;
                    btn_phase[us] = PH_IDLE;
                end else if (pr) begin
                    btn_phase[us] = PH_SECOND;
                end
            end
            PH_HOLD: begin
                led_level = 1'b1;
                if (!pr) begin
                    led_level     = 1'b0;
                    btn_phase[us] = PH_IDLE;
                    btn_ticks[us] = '0;
                end
            end
            PH_SECOND: begin
                if (!pr) begin
                    r.double_event = 1'b1;
                    btn_phase[us]  = PH_FLASH;
                end
            end
            PH_FLASH: begin
                t = sat_inc(btn_ticks[us]);
                btn_ticks[us] = t;
                if (t <= FLASH1_END) begin
                    led_level = 1'b1;
                end else if (t >= FLASH2_BEGIN && t <= FLASH2_END) begin
                    led_level = 1'b1;
                end else if (t >= FLASH3_BEGIN && t <= FLASH3_END) begin
                    led_level = 1'b1;
                end else if (t > FLASH3_END) begin
                    led_level     = 1'b0;
                    btn_ticks[us] = '0;
                    btn_phase[us] = PH_IDLE;
                end else begin
                    led_level = 1'b0;
                end
            end
            default: begin
                btn_phase[us] = PH_IDLE;
                btn_ticks[us] = '0;
            end
        endcase
        r.led_on       = led_level;
        r.event_source = (r.single_event | r.double_event) & us;
        return r;
    endfunction

    task automatic send_tick(input logic fp, input logic sp, input logic us,
                             input logic typed, input t_tick_res typed_res);
        int        gap;
        t_tick_res r;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid          <= 1'b1;
        i_first_pressed  <= fp;
        i_second_pressed <= sp;
        i_use_second     <= us;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        r = classify_tick(fp, sp, us);
        if (typed) r = typed_res;
        tick_results_q.push_back(r);
        n_single   += r.single_event;
        n_double   += r.double_event;
        n_items++;
        burst_left--;
    endtask

    // tick for button b at level lvl, now and then preceded by noise on the other one
    task automatic press_tick(input logic b, input logic lvl);
        if ($urandom_range(0, 7) == 0)
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), ~b, 1'b0, '0);
        if (b)
            send_tick(1'($urandom_range(0, 1)), lvl, 1'b1, 1'b0, '0);
        else
            send_tick(lvl, 1'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
    endtask

    task automatic run_scenario();
        logic b;
        int   kind;
        int   wlim;
        int   n;
        b    = 1'($urandom_range(0, 1));
        kind = $urandom_range(0, 7);
        wlim = (window_cfg > 40) ? 40 : window_cfg;
        if ($urandom_range(0, 7) == 0) wlim = window_cfg;
        case (kind)
            0, 1: begin
                press_tick(b, 1'b1);
                repeat ($urandom_range(12, 30)) press_tick(b, 1'b1);
                repeat ($urandom_range(1, wlim + 5)) press_tick(b, 1'b0);
            end
            2: begin
                press_tick(b, 1'b1);
                repeat (15) press_tick(b, 1'b1);
                press_tick(b, 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    repeat ($urandom_range(1, 4)) press_tick(b, 1'b1);
                    press_tick(b, 1'b0);
                end
                repeat ($urandom_range(0, 140)) press_tick(b, 1'b0);
            end
            3, 4, 5: begin
                press_tick(b, 1'b1);
                repeat ($urandom_range(0, 14)) press_tick(b, 1'b1);
                repeat ($urandom_range(1, wlim + 5)) press_tick(b, 1'b0);
                repeat ($urandom_range(1, 6)) press_tick(b, 1'b1);
                n = $urandom_range(100, 130);
                repeat (n) press_tick(b, 1'b0);
            end
            default: begin
                repeat ($urandom_range(4, 30))
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
            end
        endcase
    endtask

    task automatic apb_xfer(input logic wr, input logic [WINDOW_W-1:0] val,
                            output logic [WINDOW_W-1:0] rd);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_DOUBLE_WINDOW;
        pwdata  <= {24'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata[WINDOW_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (rdy_cnt == 0) begin
            rdy_mode <= $urandom_range(0, 2);
            rdy_cnt  <= $urandom_range(20, 200);
        end else begin
            rdy_cnt <= rdy_cnt - 1;
        end
        case (rdy_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_tick_res got;
        t_tick_res want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_led_on, o_single_event, o_double_event, o_event_source};
            if (tick_results_q.size() == 0) begin
                n_mism++;
                if (n_mism <= 10)
                    $display("result with no pending transaction: led %b single %b double %b src %b",
                             got.led_on, got.single_event, got.double_event,
                             got.event_source);
            end else begin
                want = tick_results_q.pop_front();
                if (got !== want) begin
                    n_mism++;
                    if (n_mism <= 10)
                        $display("result differs: led %b/%b single %b/%b double %b/%b src %b/%b",
                                 want.led_on, got.led_on, want.single_event,
                                 got.single_event, want.double_event, got.double_event,
                                 want.event_source, got.event_source);
                end
            end
        end
    end

    initial begin
        int                  target;
        logic [WINDOW_W-1:0] wval;
        logic [WINDOW_W-1:0] rd;
        window_cfg = WINDOW_RESET;
        btn_phase  = '{PH_IDLE, PH_IDLE};
        btn_ticks  = '{'0, '0};
        led_level  = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[k])
            send_tick(DIR_ROWS[k][7], DIR_ROWS[k][6], DIR_ROWS[k][5], DIR_ROWS[k][4],
                      t_tick_res'(DIR_ROWS[k][3:0]));

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                i_valid <= 1'b0;
                burst_left = 0;
                while (tick_results_q.size() != 0) @(posedge i_clk);
                repeat (4) @(posedge i_clk);
                case (ph)
                    1:       wval = 8'd0;
                    2:       wval = 8'd255;
                    3:       wval = 8'd1;
                    4:       wval = 8'd16;
                    default: wval = 8'($urandom_range(0, 255));
                endcase
                apb_xfer(1'b1, wval, rd);
                window_cfg = wval;
                apb_xfer(1'b0, '0, rd);
                if (rd !== window_cfg) begin
                    n_mism++;
                    if (n_mism <= 10)
                        $display("double_window read back %0d, written %0d", rd, window_cfg);
                end
            end
            target = n_items + N_RANDOM / N_PHASES;
            while (n_items < target) run_scenario();
        end

        i_valid <= 1'b0;
        while (tick_results_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("%0d ticks over %0d double_window settings, both buttons interleaved",
                 n_items, N_PHASES);
        $display("%0d single and %0d double presses predicted", n_single, n_double);
        if (n_mism == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
